/* src/assert_macros.svh */
// Assertion helpers used by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* src/locr_pkg.sv */
`timescale 1ns / 1ps

package locr_pkg;

    localparam int KEY_W         = 64;
    localparam int LEN_W         = 20;
    localparam int SLOT_W        = 6;
    localparam int STAMP_W       = 32;
    localparam int ENTRIES_DEF   = 10;
    localparam int KEY_WIDTH_DEF = 64;

    localparam logic [LEN_W-1:0] MAX_LEN_RST = 20'd102400;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

endpackage

/* src/locr_req_if.sv */
`timescale 1ns / 1ps

interface locr_req_if import locr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] obj_len;

    modport source (output valid, output mode, output key, output obj_len, input ready);
    modport sink   (input valid, input mode, input key, input obj_len, output ready);
endinterface

/* src/locr_rsp_if.sv */
`timescale 1ns / 1ps

interface locr_rsp_if import locr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  stored_len;
    logic              accepted;

    modport source (output valid, output hit, output slot, output stored_len,
                    output accepted, input ready);
    modport sink   (input valid, input hit, input slot, input stored_len,
                    input accepted, output ready);
endinterface

/* src/locr_cfg_if.sv */
`timescale 1ns / 1ps

interface locr_cfg_if import locr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/lru_object_cache_table_core.sv */
// Fully associative object table with least-recently-used replacement.
// req carries a lookup or an insert (mode, key, obj_len); rsp returns one
// result per request (hit, slot, stored_len, accepted); cfg writes the
// largest object length an insert may store and is always ready.
// All slots live in one synchronous memory, one word {key, length, stamp} per
// slot, read one slot per cycle, so the scan over the memory port sets the timing.
// An insert into a table that is not yet full, a too-long insert and a lookup
// on an empty table go from the request straight to the result state; a
// lookup with n filled slots scans them in order and stops at the first
// match; an insert into a full table searches every stamp for the oldest
// slot.
// One request is worked on at a time; the next one is taken as soon as the
// previous result has moved into the output register.
// Reset empties the table and clears the stamp counter; slot contents are
// not cleared. If the receiver stalls, the result waits in the output
// register, one more finished result waits behind it, and req.ready stays low.
`timescale 1ns / 1ps

module lru_object_cache_table_core
    import locr_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    locr_req_if.sink   req,
    locr_rsp_if.source rsp,
    locr_cfg_if.sink   cfg
);

`include "assert_macros.svh"

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ENTRY_W = KEY_WIDTH + LEN_W + STAMP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [CNT_W-1:0]     end_reg, end_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [STAMP_W-1:0]   best_reg, best_next;
    logic [IDX_W-1:0]     victim_reg, victim_next;
    logic [CNT_W-1:0]     filled_reg, filled_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [LEN_W-1:0]     max_len_reg, max_len_next;

    logic                 res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [LEN_W-1:0]     res_len_reg, res_len_next;
    logic                 res_acc_reg, res_acc_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [LEN_W-1:0]     out_len_reg, out_len_next;
    logic                 out_acc_reg, out_acc_next;

    logic [ENTRY_W-1:0]   mem [ENTRIES];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ENTRY_W-1:0]   mem_wdata;

    logic [KEY_WIDTH-1:0] rd_key;
    logic [LEN_W-1:0]     rd_len;
    logic [STAMP_W-1:0]   rd_stamp;
    logic [KEY_WIDTH-1:0] key_in;
    logic [CNT_W-1:0]     end_last;
    logic                 issue;
    logic                 cmp_last;
    logic                 take;
    logic [IDX_W-1:0]     victim_final;

    assign rd_key   = rd_data_reg[ENTRY_W-1 -: KEY_WIDTH];
    assign rd_len   = rd_data_reg[STAMP_W +: LEN_W];
    assign rd_stamp = rd_data_reg[STAMP_W-1:0];
    assign key_in   = req.key[KEY_WIDTH-1:0];
    assign end_last = end_reg - CNT_W'(1);
    assign issue    = scan_idx_reg < end_reg;
    assign cmp_last = cmp_vld_reg && (CNT_W'(cmp_idx_reg) == end_last);
    assign take     = (cmp_idx_reg == '0) || (rd_stamp < best_reg);
    assign victim_final = take ? cmp_idx_reg : victim_reg;

    assign req.ready      = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.slot       = out_slot_reg;
    assign rsp.stored_len = out_len_reg;
    assign rsp.accepted   = out_acc_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        len_next      = len_reg;
        end_next      = end_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_next     = best_reg;
        victim_next   = victim_reg;
        filled_next   = filled_reg;
        stamp_next    = stamp_reg;
        max_len_next  = max_len_reg;
        res_hit_next  = res_hit_reg;
        res_slot_next = res_slot_reg;
        res_len_next  = res_len_reg;
        res_acc_next  = res_acc_reg;
        out_valid_next = out_valid_reg;
        out_hit_next  = out_hit_reg;
        out_slot_next = out_slot_reg;
        out_len_next  = out_len_reg;
        out_acc_next  = out_acc_reg;
        rd_en         = 1'b0;
        rd_addr       = scan_idx_reg[IDX_W-1:0];
        mem_we        = 1'b0;
        mem_waddr     = victim_final;
        mem_wdata     = {key_reg, len_reg, stamp_reg};

        if (cfg.valid)
        begin
            max_len_next = cfg.data;
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next     = req.mode;
                    key_next      = key_in;
                    len_next      = req.obj_len;
                    res_hit_next  = 1'b0;
                    res_slot_next = '0;
                    res_len_next  = '0;
                    res_acc_next  = 1'b0;
                    scan_idx_next = '0;
                    state_next    = ST_RESP;
                    if (req.mode == MODE_INSERT)
                    begin
                        if (req.obj_len > max_len_reg)
                        begin
                            state_next = ST_RESP;
                        end
                        else if (filled_reg < CNT_W'(ENTRIES))
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = filled_reg[IDX_W-1:0];
                            mem_wdata     = {key_in, req.obj_len, stamp_reg};
                            stamp_next    = stamp_reg + STAMP_W'(1);
                            filled_next   = filled_reg + CNT_W'(1);
                            res_slot_next = SLOT_W'(filled_reg);
                            res_acc_next  = 1'b1;
                        end
                        else
                        begin
                            end_next   = CNT_W'(ENTRIES);
                            state_next = ST_SCAN;
                        end
                    end
                    else if (filled_reg != '0)
                    begin
                        end_next   = filled_reg;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Reads are pipelined: the slot addressed now is compared next cycle.
                rd_en         = issue;
                cmp_vld_next  = issue;
                cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                scan_idx_next = scan_idx_reg + CNT_W'(issue);
                if (cmp_vld_reg)
                begin
                    if (mode_reg == MODE_LOOKUP)
                    begin
                        if (rd_key == key_reg)
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = cmp_idx_reg;
                            mem_wdata     = {rd_key, rd_len, stamp_reg};
                            stamp_next    = stamp_reg + STAMP_W'(1);
                            res_hit_next  = 1'b1;
                            res_slot_next = SLOT_W'(cmp_idx_reg);
                            res_len_next  = rd_len;
                            state_next    = ST_RESP;
                        end
                        else if (cmp_last)
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    else
                    begin
                        // Strict compare keeps the lowest slot among equal stamps.
                        if (take)
                        begin
                            best_next   = rd_stamp;
                            victim_next = cmp_idx_reg;
                        end
                        if (cmp_last)
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = victim_final;
                            mem_wdata     = {key_reg, len_reg, stamp_reg};
                            stamp_next    = stamp_reg + STAMP_W'(1);
                            res_slot_next = SLOT_W'(victim_final);
                            res_acc_next  = 1'b1;
                            state_next    = ST_RESP;
                        end
                    end
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_slot_next  = res_slot_reg;
                    out_len_next   = res_len_reg;
                    out_acc_next   = res_acc_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_LOOKUP;
            key_reg       <= '0;
            len_reg       <= '0;
            end_reg       <= '0;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            best_reg      <= '0;
            victim_reg    <= '0;
            filled_reg    <= '0;
            stamp_reg     <= '0;
            max_len_reg   <= MAX_LEN_RST;
            res_hit_reg   <= 1'b0;
            res_slot_reg  <= '0;
            res_len_reg   <= '0;
            res_acc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_slot_reg  <= '0;
            out_len_reg   <= '0;
            out_acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            key_reg       <= key_next;
            len_reg       <= len_next;
            end_reg       <= end_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            best_reg      <= best_next;
            victim_reg    <= victim_next;
            filled_reg    <= filled_next;
            stamp_reg     <= stamp_next;
            max_len_reg   <= max_len_next;
            res_hit_reg   <= res_hit_next;
            res_slot_reg  <= res_slot_next;
            res_len_reg   <= res_len_next;
            res_acc_reg   <= res_acc_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_slot_reg  <= out_slot_next;
            out_len_reg   <= out_len_next;
            out_acc_reg   <= out_acc_next;
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `ASSERT_SAME(a_fill_bound, 1'b1, filled_reg <= CNT_W'(ENTRIES), "fill count above table size")
    `ASSERT_NEXT(a_stamp_step, mem_we, stamp_reg == $past(stamp_reg) + 32'd1, "stamp did not advance on write")
    `ASSERT_SAME(a_insert_scan_full, (state_reg == ST_SCAN) && (mode_reg == MODE_INSERT), filled_reg == CNT_W'(ENTRIES), "victim search on a table that is not full")

endmodule
